[design/assert_macros.svh]
// Assertion macros shared by the counter/timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CTC_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define CTC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
`else
`define CTC_ASSERT(label, clk, rst_n, expr)
`define CTC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

[design/ctc_pkg.sv]
// Types, constants and helpers for the four-channel counter/timer unit.
package ctc_pkg;

    localparam int NUM_CHANNELS_DEF = 4;

    localparam int CMD_W    = 3;
    localparam int CH_W     = 2;
    localparam int DATA_W   = 8;
    localparam int CYC_W    = 5;
    localparam int ZMASK_W  = 4;
    localparam int MODE_W   = 9;
    localparam int TC_W     = 9;
    localparam int TIMER_W  = 17;
    localparam int VEC_W    = 5;
    localparam int INH_W    = 4;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Bit positions inside the stored mode word.
    localparam int MB_WAIT      = 8;
    localparam int MB_INT       = 7;
    localparam int MB_COUNTER   = 6;
    localparam int MB_PRE256    = 5;
    localparam int MB_RISING    = 4;
    localparam int MB_TRIGSTART = 3;
    localparam int MB_CONST     = 2;
    localparam int MB_RESET     = 1;
    localparam int MB_CONTROL   = 0;

    localparam logic [MODE_W-1:0] MODE_RESET_VAL = 9'h002;
    localparam logic [TC_W-1:0]   TC_RESET_VAL   = 9'h100;
    localparam logic [CYC_W-1:0]  TICK_MAX       = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 3'd0,
        CMD_READ    = 3'd1,
        CMD_TRIGGER = 3'd2,
        CMD_TICK    = 3'd3,
        CMD_ACK     = 3'd4,
        CMD_RETI    = 3'd5
    } cmd_t;

    typedef enum logic [0:0] {
        REG_TIMER_INHIBIT = 1'b0
    } cfg_reg_t;

    // Timer period in cycles: time constant times a prescale of 16 or 256.
    function automatic logic [TIMER_W-1:0] timer_target_f(input logic [TC_W-1:0] tc,
                                                          input logic pre256);
        timer_target_f = pre256 ? {tc, 8'b0} : {4'b0, tc, 4'b0};
    endfunction

endpackage

[design/four_channel_counter_timer_unit.sv]
// Four-channel counter/timer unit with daisy-chain interrupt priority.
//
// Requests enter on the s_ channel (valid/ready) and carry a command, a channel,
// a data byte and a cycle count. Every request produces exactly one result on
// the m_ channel: read data (count or interrupt vector), a per-channel mask of
// channels that reached zero, and the current interrupt request line.
// The request is registered in the input register at acceptance; from there all
// channel updates are evaluated in parallel by shallow logic and the result is
// captured in the output register once that register is empty or being read.
// With the receiver ready, throughput is one request per cycle.
// When the receiver stalls, the result holds in the output register and one more
// request waits in the input register; after that s_ready drops until the
// result is taken. The timer inhibit mask is written through the APB port and
// must only change while the unit is idle.
// A synchronous active-low reset puts every channel into its reset mode word,
// loads a time constant of 256, clears counts, pending and in-service flags,
// stops all timers and empties both pipeline registers.
module four_channel_counter_timer_unit #(
    parameter int NUM_CHANNELS = ctc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ctc_pkg::CMD_W-1:0]    s_command,
    input  logic [ctc_pkg::CH_W-1:0]     s_channel,
    input  logic [ctc_pkg::DATA_W-1:0]   s_data,
    input  logic [ctc_pkg::CYC_W-1:0]    s_cycles,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ctc_pkg::DATA_W-1:0]   m_read_data,
    output logic [ctc_pkg::ZMASK_W-1:0]  m_zero_mask,
    output logic                         m_irq_line,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ctc_pkg::APB_AW-1:0]   paddr,
    input  logic [ctc_pkg::APB_DW-1:0]   pwdata,
    output logic [ctc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import ctc_pkg::*;
`include "assert_macros.svh"

    // Input register.
    logic                in_valid_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [CYC_W-1:0]    cycles_reg;

    // Output register.
    logic                out_valid_reg;
    logic [DATA_W-1:0]   rd_reg, rd_next;
    logic [ZMASK_W-1:0]  zmask_reg, zmask_next;
    logic                irq_reg, irq_next;

    // Configuration and channel state.
    logic [INH_W-1:0]        inhibit_reg;
    logic [VEC_W-1:0]        vector_reg, vector_next;
    logic [MODE_W-1:0]       mode_reg    [NUM_CHANNELS];
    logic [MODE_W-1:0]       mode_next   [NUM_CHANNELS];
    logic [TC_W-1:0]         tc_reg      [NUM_CHANNELS];
    logic [TC_W-1:0]         tc_next     [NUM_CHANNELS];
    logic [TC_W-1:0]         cnt_reg     [NUM_CHANNELS];
    logic [TC_W-1:0]         cnt_next    [NUM_CHANNELS];
    logic [TIMER_W-1:0]      target_reg  [NUM_CHANNELS];
    logic [TIMER_W-1:0]      target_next [NUM_CHANNELS];
    logic [TIMER_W-1:0]      elapsed_reg [NUM_CHANNELS];
    logic [TIMER_W-1:0]      elapsed_next[NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] lvl_reg, lvl_next;
    logic [NUM_CHANNELS-1:0] pend_reg, pend_next;
    logic [NUM_CHANNELS-1:0] isr_reg, isr_next;
    logic [NUM_CHANNELS-1:0] run_reg, run_next;

    // Helpers for the item being processed.
    logic                    advance;
    logic                    cfg_write;
    logic [NUM_CHANNELS-1:0] sel;
    logic [TC_W-1:0]         tc_load;
    logic [CYC_W-1:0]        cyc_sat;
    logic                    trig_lvl_in;
    logic [TIMER_W:0]        tick_sum    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] tick_hit;
    logic [TC_W-1:0]         cnt_dec     [NUM_CHANNELS];
    logic [TIMER_W-1:0]      start_target[NUM_CHANNELS];
    logic [TIMER_W-1:0]      load_target [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] ack_onehot;
    logic [NUM_CHANNELS-1:0] reti_onehot;
    logic [CH_W-1:0]         ack_ch;
    logic                    ack_found;
    logic                    reti_found;
    logic [MODE_W-1:0]       rd_mode;
    logic [TC_W-1:0]         rd_cnt;
    logic                    rd_run;
    logic [TIMER_W-1:0]      rd_target;
    logic [TIMER_W-1:0]      rd_elapsed;
    logic [TIMER_W-1:0]      rd_left;
    logic [TIMER_W-1:0]      rd_scaled;
    logic [DATA_W-1:0]       read_val;
    logic                    irq_done;

    // The request moves into the output register whenever that register is
    // empty or its result is being taken this cycle.
    assign advance     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready     = !in_valid_reg || advance;
    assign m_valid     = out_valid_reg;
    assign m_read_data = rd_reg;
    assign m_zero_mask = zmask_reg;
    assign m_irq_line  = irq_reg;

    // APB: pready is tied high, one register at word address zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TIMER_INHIBIT);
    assign prdata    = (psel && paddr[2] == REG_TIMER_INHIBIT) ? APB_DW'(inhibit_reg) : '0;

    // A time constant byte of zero stands for 256.
    assign tc_load     = (data_reg != '0) ? {1'b0, data_reg} : TC_RESET_VAL;
    // A tick's cycle count saturates at TICK_MAX, so a timer fires at most once.
    assign cyc_sat     = (cycles_reg > TICK_MAX) ? TICK_MAX : cycles_reg;
    assign trig_lvl_in = |data_reg;

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            sel[i]          = (ch_reg == CH_W'(i));
            tick_sum[i]     = {1'b0, elapsed_reg[i]} + (TIMER_W + 1)'(cyc_sat);
            tick_hit[i]     = tick_sum[i] >= {1'b0, target_reg[i]};
            cnt_dec[i]      = cnt_reg[i] - 1'b1;
            start_target[i] = timer_target_f(tc_reg[i], mode_reg[i][MB_PRE256]);
            load_target[i]  = timer_target_f(tc_load, mode_reg[i][MB_PRE256]);
        end
    end

    // Daisy chain: the lowest numbered channel wins for acknowledge and return.
    always_comb begin
        ack_onehot  = '0;
        reti_onehot = '0;
        ack_ch      = '0;
        ack_found   = 1'b0;
        reti_found  = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (pend_reg[i] && !ack_found) begin
                ack_onehot[i] = 1'b1;
                ack_ch        = CH_W'(i);
                ack_found     = 1'b1;
            end
            if (isr_reg[i] && !reti_found) begin
                reti_onehot[i] = 1'b1;
                reti_found     = 1'b1;
            end
        end
    end

    // Read path: counters and waiting timers show the count; a running timer
    // shows remaining prescaler periods plus one; a stopped timer shows zero.
    always_comb begin
        rd_mode    = '0;
        rd_cnt     = '0;
        rd_run     = 1'b0;
        rd_target  = '0;
        rd_elapsed = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (sel[i]) begin
                rd_mode    = mode_reg[i];
                rd_cnt     = cnt_reg[i];
                rd_run     = run_reg[i];
                rd_target  = target_reg[i];
                rd_elapsed = elapsed_reg[i];
            end
        end
        rd_left   = rd_target - rd_elapsed;
        rd_scaled = (rd_mode[MB_PRE256] ? (rd_left >> 8) : (rd_left >> 4)) + 1'b1;
        if (rd_mode[MB_COUNTER] || rd_mode[MB_WAIT]) begin
            read_val = rd_cnt[DATA_W-1:0];
        end else if (rd_run) begin
            read_val = rd_scaled[DATA_W-1:0];
        end else begin
            read_val = '0;
        end
    end

    // Next state of every channel for the request in the input register.
    always_comb begin
        vector_next  = vector_reg;
        mode_next    = mode_reg;
        tc_next      = tc_reg;
        cnt_next     = cnt_reg;
        target_next  = target_reg;
        elapsed_next = elapsed_reg;
        lvl_next     = lvl_reg;
        pend_next    = pend_reg;
        isr_next     = isr_reg;
        run_next     = run_reg;
        rd_next      = '0;
        zmask_next   = '0;
        case (cmd_t'(cmd_reg))
            CMD_WRITE: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (sel[i]) begin
                        if (mode_reg[i][MB_CONST]) begin
                            // Time constant byte.
                            tc_next[i]            = tc_load;
                            cnt_next[i]           = tc_load;
                            mode_next[i][MB_CONST] = 1'b0;
                            mode_next[i][MB_RESET] = 1'b0;
                            if (!mode_reg[i][MB_COUNTER]) begin
                                if (!mode_reg[i][MB_TRIGSTART]) begin
                                    elapsed_next[i] = '0;
                                    if (inhibit_reg[i]) begin
                                        run_next[i] = 1'b0;
                                    end else begin
                                        target_next[i] = load_target[i];
                                        run_next[i]    = 1'b1;
                                    end
                                end else begin
                                    mode_next[i][MB_WAIT] = 1'b1;
                                end
                            end
                        end else if (!data_reg[MB_CONTROL]) begin
                            // Vector byte, honored on channel 0 only.
                            if (i == 0) begin
                                vector_next = data_reg[DATA_W-1:3];
                            end
                        end else begin
                            // Control word; a reset stops the timer.
                            mode_next[i] = {1'b0, data_reg};
                            if (data_reg[MB_RESET]) begin
                                run_next[i]     = 1'b0;
                                elapsed_next[i] = '0;
                            end
                        end
                    end
                end
            end
            CMD_READ: begin
                rd_next = read_val;
            end
            CMD_TRIGGER: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (sel[i] && (trig_lvl_in != lvl_reg[i])) begin
                        lvl_next[i] = trig_lvl_in;
                        if (mode_reg[i][MB_RISING] == trig_lvl_in) begin
                            if (mode_reg[i][MB_WAIT] && !mode_reg[i][MB_COUNTER]) begin
                                elapsed_next[i] = '0;
                                if (inhibit_reg[i]) begin
                                    run_next[i] = 1'b0;
                                end else begin
                                    target_next[i] = start_target[i];
                                    run_next[i]    = 1'b1;
                                end
                            end
                            mode_next[i][MB_WAIT] = 1'b0;
                            if (mode_reg[i][MB_COUNTER]) begin
                                if (cnt_dec[i] == '0) begin
                                    if (mode_reg[i][MB_INT]) begin
                                        pend_next[i] = 1'b1;
                                    end
                                    zmask_next[i] = 1'b1;
                                    cnt_next[i]   = tc_reg[i];
                                end else begin
                                    cnt_next[i] = cnt_dec[i];
                                end
                            end
                        end
                    end
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (run_reg[i] && (target_reg[i] != '0)) begin
                        if (tick_hit[i]) begin
                            if (mode_reg[i][MB_INT]) begin
                                pend_next[i] = 1'b1;
                            end
                            zmask_next[i]   = 1'b1;
                            cnt_next[i]     = tc_reg[i];
                            elapsed_next[i] = TIMER_W'(tick_sum[i] - {1'b0, target_reg[i]});
                        end else begin
                            elapsed_next[i] = tick_sum[i][TIMER_W-1:0];
                        end
                    end
                end
            end
            CMD_ACK: begin
                pend_next = pend_reg & ~ack_onehot;
                isr_next  = isr_reg | ack_onehot;
                rd_next   = ack_found ? {vector_reg, ack_ch, 1'b0} : {vector_reg, 3'b000};
            end
            CMD_RETI: begin
                isr_next = isr_reg & ~reti_onehot;
            end
            default: begin
            end
        endcase
    end

    // Interrupt line after the update: a channel in service blocks all below it.
    always_comb begin
        irq_next = 1'b0;
        irq_done = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (!irq_done) begin
                if (isr_next[i]) begin
                    irq_done = 1'b1;
                end else if (pend_next[i]) begin
                    irq_next = 1'b1;
                    irq_done = 1'b1;
                end
            end
        end
    end

    // Control and channel state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            inhibit_reg   <= '0;
            vector_reg    <= '0;
            lvl_reg       <= '0;
            pend_reg      <= '0;
            isr_reg       <= '0;
            run_reg       <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                mode_reg[i]    <= MODE_RESET_VAL;
                tc_reg[i]      <= TC_RESET_VAL;
                cnt_reg[i]     <= '0;
                target_reg[i]  <= '0;
                elapsed_reg[i] <= '0;
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write) begin
                inhibit_reg <= pwdata[INH_W-1:0];
            end
            if (advance) begin
                vector_reg  <= vector_next;
                lvl_reg     <= lvl_next;
                pend_reg    <= pend_next;
                isr_reg     <= isr_next;
                run_reg     <= run_next;
                mode_reg    <= mode_next;
                tc_reg      <= tc_next;
                cnt_reg     <= cnt_next;
                target_reg  <= target_next;
                elapsed_reg <= elapsed_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg    <= s_command;
            ch_reg     <= s_channel;
            data_reg   <= s_data;
            cycles_reg <= s_cycles;
        end
        if (advance) begin
            rd_reg    <= rd_next;
            zmask_reg <= zmask_next;
            irq_reg   <= irq_next;
        end
    end

    // An empty output register always frees the input side.
    `CTC_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_ready)
    // A held result with a waiting request must block new requests.
    `CTC_ASSERT_IMPL(a_stall_blocks, aclk, aresetn, in_valid_reg && out_valid_reg && !m_ready,
                     !s_ready)

    // A running timer always has a nonzero period and stays inside it.
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chk
        `CTC_ASSERT(a_run_period, aclk, aresetn, !run_reg[g] || (target_reg[g] != '0))
        `CTC_ASSERT(a_run_inside, aclk, aresetn, !run_reg[g] || (elapsed_reg[g] < target_reg[g]))
    end

endmodule

[tb/four_channel_counter_timer_unit_test.sv]
// Self-checking testbench for the four-channel counter/timer unit.
`timescale 1ns / 1ps

module four_channel_counter_timer_unit_test;
    import ctc_pkg::*;

    localparam int NCH = NUM_CHANNELS_DEF;

    // Commands the block must accept and answer with no read data and no zero events.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    // Control byte bits, built from the package bit positions.
    localparam logic [DATA_W-1:0] CW_CONTROL   = DATA_W'(1 << MB_CONTROL);
    localparam logic [DATA_W-1:0] CW_RESET     = DATA_W'(1 << MB_RESET);
    localparam logic [DATA_W-1:0] CW_CONST     = DATA_W'(1 << MB_CONST);
    localparam logic [DATA_W-1:0] CW_TRIGSTART = DATA_W'(1 << MB_TRIGSTART);
    localparam logic [DATA_W-1:0] CW_RISING    = DATA_W'(1 << MB_RISING);
    localparam logic [DATA_W-1:0] CW_PRE256    = DATA_W'(1 << MB_PRE256);
    localparam logic [DATA_W-1:0] CW_COUNTER   = DATA_W'(1 << MB_COUNTER);
    localparam logic [DATA_W-1:0] CW_INT       = DATA_W'(1 << MB_INT);

    // Wait after a drain that covers the input and output registers of the unit.
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_PRINTED    = 30;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CH_W-1:0]   channel;
        logic [DATA_W-1:0] data;
        logic [CYC_W-1:0]  cycles;
    } ctc_request_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [ZMASK_W-1:0] zero_mask;
        logic               irq_line;
    } ctc_response_t;

    // Clock, reset and every DUT input start from known values.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command = '0;
    logic [CH_W-1:0]      s_channel = '0;
    logic [DATA_W-1:0]    s_data    = '0;
    logic [CYC_W-1:0]     s_cycles  = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [DATA_W-1:0]    m_read_data;
    logic [ZMASK_W-1:0]   m_zero_mask;
    logic                 m_irq_line;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [APB_AW-1:0]    paddr     = '0;
    logic [APB_DW-1:0]    pwdata    = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    four_channel_counter_timer_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_channel   (s_channel),
        .s_data      (s_data),
        .s_cycles    (s_cycles),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_zero_mask (m_zero_mask),
        .m_irq_line  (m_irq_line),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 aclk = ~aclk;

    // Shadow copy of the unit's state, advanced once per accepted request.
    logic [INH_W-1:0]   inhibit_mask;
    logic [VEC_W-1:0]   vec_base;
    logic [MODE_W-1:0]  mode_q    [NCH];
    logic [TC_W-1:0]    tconst_q  [NCH];
    logic [TC_W-1:0]    count_q   [NCH];
    logic               trig_lvl_q[NCH];
    logic               pend_q    [NCH];
    logic               serv_q    [NCH];
    logic               run_q     [NCH];
    logic [TIMER_W-1:0] target_q  [NCH];
    logic [TIMER_W-1:0] elapsed_q [NCH];

    // Responses predicted for accepted requests, oldest first.
    ctc_response_t responses_due[$];

    // Pacing controls and run statistics.
    bit source_gaps_on  = 1'b0;
    bit sink_stalls_on  = 1'b0;
    int stall_left      = 0;
    int cycle_count     = 0;
    int mismatches      = 0;
    int requests_sent   = 0;
    int directed_count  = 0;
    int responses_seen  = 0;
    int zero_events     = 0;
    int irq_responses   = 0;

    function automatic int scale_of(int ch);
        return mode_q[ch][MB_PRE256] ? 256 : 16;
    endfunction

    // A start request either arms the timer for a full period or, when the
    // channel is inhibited, leaves it stopped.
    function automatic void start_timer(int ch);
        elapsed_q[ch] = '0;
        if (inhibit_mask[ch]) begin
            run_q[ch] = 1'b0;
        end else begin
            target_q[ch] = TIMER_W'(scale_of(ch) * int'(tconst_q[ch]));
            run_q[ch]    = 1'b1;
        end
    endfunction

    function automatic logic [ZMASK_W-1:0] expire_channel(int ch);
        if (mode_q[ch][MB_INT])
            pend_q[ch] = 1'b1;
        count_q[ch] = tconst_q[ch];
        return ZMASK_W'(1 << ch);
    endfunction

    // Predicts the response to one request and moves the shadow state on.
    function automatic ctc_response_t compute_ctc_response(input ctc_request_t req);
        ctc_response_t      res;
        int                 c;
        logic [MODE_W-1:0]  m;
        logic               lvl;
        logic               done;
        logic [CYC_W-1:0]   cyc;
        logic [TIMER_W:0]   sum;
        logic [TIMER_W-1:0] remaining;
        res = '0;
        c   = int'(req.channel);
        m   = mode_q[c];
        case (req.command)
            CMD_WRITE: begin
                if (m[MB_CONST]) begin
                    // Time constant byte; zero stands for 256.
                    tconst_q[c] = (req.data == 0) ? TC_RESET_VAL : TC_W'(req.data);
                    mode_q[c][MB_CONST] = 1'b0;
                    mode_q[c][MB_RESET] = 1'b0;
                    if (!m[MB_COUNTER]) begin
                        if (!m[MB_TRIGSTART])
                            start_timer(c);
                        else
                            mode_q[c][MB_WAIT] = 1'b1;
                    end
                    count_q[c] = tconst_q[c];
                end else if (!req.data[MB_CONTROL]) begin
                    if (c == 0)
                        vec_base = req.data[DATA_W-1:3];
                end else begin
                    mode_q[c] = MODE_W'(req.data);
                    if (req.data[MB_RESET]) begin
                        run_q[c]     = 1'b0;
                        elapsed_q[c] = '0;
                    end
                end
            end
            CMD_READ: begin
                if (m[MB_COUNTER] || m[MB_WAIT]) begin
                    res.read_data = count_q[c][DATA_W-1:0];
                end else if (run_q[c]) begin
                    remaining     = target_q[c] - elapsed_q[c];
                    res.read_data = DATA_W'(int'(remaining) / scale_of(c) + 1);
                end
            end
            CMD_TRIGGER: begin
                lvl = (req.data != 0);
                if (lvl != trig_lvl_q[c]) begin
                    trig_lvl_q[c] = lvl;
                    if (m[MB_RISING] == lvl) begin
                        if (m[MB_WAIT] && !m[MB_COUNTER])
                            start_timer(c);
                        mode_q[c][MB_WAIT] = 1'b0;
                        if (m[MB_COUNTER]) begin
                            count_q[c] = count_q[c] - 1'b1;
                            if (count_q[c] == 0)
                                res.zero_mask |= expire_channel(c);
                        end
                    end
                end
            end
            CMD_TICK: begin
                cyc = (req.cycles > TICK_MAX) ? TICK_MAX : req.cycles;
                for (int ch = 0; ch < NCH; ch++) begin
                    if (run_q[ch] && target_q[ch] != 0) begin
                        sum = {1'b0, elapsed_q[ch]} + (TIMER_W + 1)'(cyc);
                        if (sum >= {1'b0, target_q[ch]}) begin
                            res.zero_mask |= expire_channel(ch);
                            sum = sum - {1'b0, target_q[ch]};
                        end
                        elapsed_q[ch] = sum[TIMER_W-1:0];
                    end
                end
            end
            CMD_ACK: begin
                res.read_data = {vec_base, 3'b000};
                done = 1'b0;
                for (int ch = 0; ch < NCH; ch++) begin
                    if (!done && pend_q[ch]) begin
                        pend_q[ch]    = 1'b0;
                        serv_q[ch]    = 1'b1;
                        res.read_data = {vec_base, 3'b000} + DATA_W'(2 * ch);
                        done          = 1'b1;
                    end
                end
            end
            CMD_RETI: begin
                done = 1'b0;
                for (int ch = 0; ch < NCH; ch++) begin
                    if (!done && serv_q[ch]) begin
                        serv_q[ch] = 1'b0;
                        done       = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        // Daisy chain: the first channel in service blocks everything below it.
        done = 1'b0;
        for (int ch = 0; ch < NCH; ch++) begin
            if (!done && serv_q[ch]) begin
                done = 1'b1;
            end else if (!done && pend_q[ch]) begin
                res.irq_line = 1'b1;
                done         = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h (response %0d, cycle %0d)",
                     what, got, want, responses_seen, cycle_count);
    endtask

    // One process both checks responses and predicts new ones. Everything is
    // sampled at the clock edge, before any of this edge's updates land, so
    // the order of processes within the time step does not matter. The
    // response is handled first: it always belongs to an older request.
    always @(posedge aclk) begin : response_checker
        ctc_response_t want;
        ctc_request_t  req;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                responses_seen++;
                zero_events   += $countones(m_zero_mask);
                if (m_irq_line === 1'b1)
                    irq_responses++;
                if (responses_due.size() == 0) begin
                    report_mismatch("response with no request waiting", 0, 0);
                end else begin
                    want = responses_due.pop_front();
                    if (m_read_data !== want.read_data)
                        report_mismatch("read_data", 32'(m_read_data), 32'(want.read_data));
                    if (m_zero_mask !== want.zero_mask)
                        report_mismatch("zero_mask", 32'(m_zero_mask), 32'(want.zero_mask));
                    if (m_irq_line !== want.irq_line)
                        report_mismatch("irq_line", 32'(m_irq_line), 32'(want.irq_line));
                end
            end
            if (s_valid && s_ready) begin
                req = '{command: s_command, channel: s_channel, data: s_data,
                        cycles: s_cycles};
                responses_due.push_back(compute_ctc_response(req));
            end
        end
    end

    // Receiver pacing: random stalls while enabled; turning
    // stalls off ends any stall still in progress.
    always @(posedge aclk) begin : sink_pacing
        if (stall_left != 0 && sink_stalls_on) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = 0;
            if (sink_stalls_on && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 16);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Watchdog expired after %0d cycles with %0d responses outstanding.",
                 cycle_count, responses_due.size());
        $display("Regression FAIL");
        $finish;
    end

    // Presents one request and returns at the edge that accepts it. Valid is
    // left high so that a following request can go out back to back; any
    // other wait must go through a gap or a drain, which lower it first.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                                input logic [DATA_W-1:0] data,
                                input logic [CYC_W-1:0] cyc);
        int gap;
        gap = (source_gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_channel <= ch;
        s_data    <= data;
        s_cycles  <= cyc;
        do @(posedge aclk); while (s_ready !== 1'b1);
        requests_sent++;
    endtask

    // A control word, followed by its time constant when the word asks for one.
    task automatic program_channel(input logic [CH_W-1:0] ch, input logic [DATA_W-1:0] cw,
                                   input logic [DATA_W-1:0] tc);
        send_request(CMD_WRITE, ch, cw, '0);
        if ((cw & CW_CONST) != 0)
            send_request(CMD_WRITE, ch, tc, '0);
    endtask

    // Holds the sender off until every predicted response has come back.
    task automatic drain_responses();
        s_valid <= 1'b0;
        while (responses_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_transfer(input logic wr, input logic [APB_AW-1:0] addr,
                                input logic [APB_DW-1:0] wdata,
                                output logic [APB_DW-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        rdata = prdata;
        if (wr)
            inhibit_mask = wdata[INH_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Changes the inhibit mask only once the unit is idle, then reads it back.
    task automatic set_inhibit_mask(input logic [INH_W-1:0] mask);
        logic [APB_AW-1:0] addr;
        logic [APB_DW-1:0] rd;
        addr = APB_AW'(int'(REG_TIMER_INHIBIT) * 4);
        drain_responses();
        apb_transfer(1'b1, addr, APB_DW'(mask), rd);
        apb_transfer(1'b0, addr, '0, rd);
        if (rd !== APB_DW'(mask))
            report_mismatch("timer_inhibit_mask readback", rd, APB_DW'(mask));
    endtask

    // Field extremes, every command and each corner the unit defines.
    task automatic test_directed_cases();
        set_inhibit_mask(4'h0);
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        // A timer that never started reads back as zero.
        send_request(CMD_READ, 2'd1, 8'h00, 5'd0);
        // Vector byte on channel 0 is taken; on another channel it is dropped.
        send_request(CMD_WRITE, 2'd0, 8'hF8, 5'd0);
        send_request(CMD_WRITE, 2'd2, 8'h50, 5'd0);
        // Acknowledge and return with nothing pending or in service.
        send_request(CMD_ACK, 2'd0, 8'h00, 5'd0);
        send_request(CMD_RETI, 2'd0, 8'h00, 5'd0);
        // Unused command codes with data and cycles at their top values.
        send_request(CMD_SPARE_A, 2'd3, 8'hFF, 5'd31);
        send_request(CMD_SPARE_B, 2'd2, 8'hFF, 5'd31);
        // Counter on falling edges decremented from zero wraps to the top.
        send_request(CMD_WRITE, 2'd3, CW_COUNTER | CW_CONTROL, 5'd0);
        send_request(CMD_TRIGGER, 2'd3, 8'hFF, 5'd0);
        send_request(CMD_TRIGGER, 2'd3, 8'h00, 5'd0);
        send_request(CMD_READ, 2'd3, 8'h00, 5'd0);
        // Time constant of zero means 256; read a running timer.
        program_channel(2'd1, CW_INT | CW_CONST | CW_CONTROL, 8'h00);
        send_request(CMD_READ, 2'd1, 8'h00, 5'd0);
        // Shortest period on channel 0; an oversized tick still fires once.
        program_channel(2'd0, CW_INT | CW_CONST | CW_RESET | CW_CONTROL, 8'h01);
        send_request(CMD_TICK, 2'd0, 8'h00, 5'd31);
        send_request(CMD_ACK, 2'd0, 8'h00, 5'd0);
        send_request(CMD_TICK, 2'd0, 8'h00, 5'd16);
        // Reset control word stops the timer yet keeps the pending request.
        send_request(CMD_WRITE, 2'd0, CW_RESET | CW_CONTROL, 5'd0);
        send_request(CMD_RETI, 2'd0, 8'h00, 5'd0);
        send_request(CMD_ACK, 2'd0, 8'h00, 5'd0);
        send_request(CMD_RETI, 2'd0, 8'h00, 5'd0);
        send_request(CMD_READ, 2'd0, 8'h00, 5'd0);
        send_request(CMD_TICK, 2'd0, 8'h00, 5'd0);
        directed_count = requests_sent;
    endtask

    // Inhibited channels: both automatic and triggered starts leave the timer
    // stopped, while an uninhibited channel started by a trigger keeps going.
    task automatic test_timer_inhibit();
        set_inhibit_mask(4'b0010);
        program_channel(2'd1, CW_INT | CW_CONST | CW_CONTROL, 8'h01);
        send_request(CMD_READ, 2'd1, 8'h00, 5'd0);
        send_request(CMD_TICK, 2'd0, 8'h00, 5'd16);
        program_channel(2'd1, CW_INT | CW_TRIGSTART | CW_RISING | CW_CONST | CW_CONTROL,
                        8'h01);
        send_request(CMD_TRIGGER, 2'd1, 8'h00, 5'd0);
        send_request(CMD_TRIGGER, 2'd1, 8'h01, 5'd0);
        send_request(CMD_READ, 2'd1, 8'h00, 5'd0);
        program_channel(2'd2, CW_INT | CW_TRIGSTART | CW_RISING | CW_CONST | CW_CONTROL,
                        8'h02);
        send_request(CMD_READ, 2'd2, 8'h00, 5'd0);
        send_request(CMD_TRIGGER, 2'd2, 8'h80, 5'd0);
        send_request(CMD_TICK, 2'd0, 8'h00, 5'd16);
        send_request(CMD_TICK, 2'd0, 8'h00, 5'd16);
        send_request(CMD_ACK, 2'd0, 8'h00, 5'd0);
    endtask

    // Mostly well-formed traffic: channels are reprogrammed with short periods
    // so that expiries, interrupts and the acknowledge chain stay busy, mixed
    // with reads, trigger edges and a little raw noise. Halfway through, the
    // sender holds off until every outstanding response has been returned.
    task automatic test_random_traffic(input logic [INH_W-1:0] mask, input int n_requests,
                                       input bit allow_idling);
        int            first;
        int            next_pace;
        int            pick;
        bit            paused;
        logic [CH_W-1:0]   ch;
        logic [DATA_W-1:0] cw;
        logic [DATA_W-1:0] tc;
        set_inhibit_mask(mask);
        first     = requests_sent;
        next_pace = 0;
        paused    = 1'b0;
        while (requests_sent - first < n_requests) begin
            // Idling comes and goes in stretches, leaving some fully busy ones.
            if (requests_sent - first >= next_pace) begin
                source_gaps_on = allow_idling && ($urandom_range(0, 2) != 0);
                sink_stalls_on = allow_idling && ($urandom_range(0, 2) != 0);
                next_pace      = next_pace + 60;
            end
            if (!paused && requests_sent - first >= n_requests / 2) begin
                drain_responses();
                paused = 1'b1;
            end
            ch   = CH_W'($urandom_range(0, NCH - 1));
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                cw = CW_CONTROL;
                if ($urandom_range(0, 9) < 8) cw |= CW_INT;
                if ($urandom_range(0, 2) == 0) cw |= CW_COUNTER;
                if ($urandom_range(0, 3) == 0) cw |= CW_PRE256;
                if ($urandom_range(0, 1) == 0) cw |= CW_RISING;
                if ($urandom_range(0, 2) == 0) cw |= CW_TRIGSTART;
                if ($urandom_range(0, 9) != 0) cw |= CW_CONST;
                if ($urandom_range(0, 1) == 0) cw |= CW_RESET;
                if ($urandom_range(0, 9) == 0)
                    tc = DATA_W'($urandom_range(0, 255));
                else if ((cw & CW_PRE256) != 0)
                    tc = DATA_W'($urandom_range(1, 3));
                else
                    tc = DATA_W'($urandom_range(1, 8));
                program_channel(ch, cw, tc);
            end else if (pick < 28) begin
                send_request(CMD_TRIGGER, ch,
                             $urandom_range(0, 1) ? DATA_W'($urandom_range(1, 255)) : '0,
                             CYC_W'($urandom_range(0, 31)));
            end else if (pick < 38) begin
                send_request(CMD_READ, ch, DATA_W'($urandom_range(0, 255)), '0);
            end else if (pick < 47) begin
                send_request(CMD_ACK, ch, '0, '0);
            end else if (pick < 55) begin
                send_request(CMD_RETI, ch, '0, '0);
            end else if (pick < 58) begin
                // Vector byte: the control bit is clear.
                send_request(CMD_WRITE, ch, DATA_W'($urandom_range(0, 255)) & ~CW_CONTROL,
                             '0);
            end else if (pick < 61) begin
                send_request(CMD_SPARE_A + CMD_W'($urandom_range(0, 1)) - CMD_W'(
                             $urandom_range(0, 1) * 6), ch,
                             DATA_W'($urandom_range(0, 255)), CYC_W'($urandom_range(0, 31)));
            end else begin
                send_request(CMD_TICK, ch, DATA_W'($urandom_range(0, 255)),
                             ($urandom_range(0, 9) < 7) ? CYC_W'($urandom_range(12, 16))
                                                        : CYC_W'($urandom_range(0, 31)));
            end
        end
    endtask

    // The test sequence. Reset is held low at the start, then each test runs
    // in turn; configuration changes happen only inside set_inhibit_mask,
    // which first waits for the unit to go idle. The closing stretch runs
    // with no idling on either side.
    initial begin : main
        for (int ch = 0; ch < NCH; ch++) begin
            mode_q[ch]     = MODE_RESET_VAL;
            tconst_q[ch]   = TC_RESET_VAL;
            count_q[ch]    = '0;
            trig_lvl_q[ch] = 1'b0;
            pend_q[ch]     = 1'b0;
            serv_q[ch]     = 1'b0;
            run_q[ch]      = 1'b0;
            target_q[ch]   = '0;
            elapsed_q[ch]  = '0;
        end
        inhibit_mask = '0;
        vec_base     = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_timer_inhibit();
        test_random_traffic(4'hF, 250, 1'b1);
        test_random_traffic(4'h0, 300, 1'b1);
        test_random_traffic(INH_W'($urandom_range(1, 14)), 250, 1'b1);
        test_random_traffic(4'hA, 100, 1'b1);
        test_random_traffic(4'h0, 150, 1'b0);

        drain_responses();
        $display("Ran %0d requests (%0d directed) through %0d responses in %0d cycles.",
                 requests_sent, directed_count, responses_seen, cycle_count);
        $display("Saw %0d channel zero events and %0d responses with the interrupt raised.",
                 zero_events, irq_responses);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches found.", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
